// ===== sv/rtq_pkg.sv =====
// Shared types and constants of the repeating timer queue.
`default_nettype none
package rtq_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int TAG_BITS_DEF  = 16;

  localparam int ID_W       = 32;
  localparam int INTERVAL_W = 24;
  localparam int REPEAT_W   = 17;
  localparam int OWNER_W    = 16;
  localparam int COUNT_W    = 5;
  localparam int AGE_W      = 32;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    CMD_SCHED      = 2'd0,
    CMD_CANCEL_ID  = 2'd1,
    CMD_CANCEL_TAG = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SCHED  = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_FIRED  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED,
    S_CANCEL,
    S_CANCEL_OUT,
    S_PEND,
    S_SEL,
    S_FIRE
  } state_t;

  // Classification of one queued command.
  typedef struct packed {
    cmd_t cmd;
    logic reject;
    logic id_zero;
    logic tag_zero;
  } ctl_t;

endpackage
`default_nettype wire

// ===== sv/repeating_timer_queue.sv =====
// Top level of the repeating timer queue.
// Commands arrive as beats on the in_ channel; in_tuser carries the command
// (schedule, cancel by id, cancel by tag, tick). A two-entry command queue
// sits in front of the slot engine, so in_tready stays high while it has room.
// Results leave as beats on the out_ channel; out_tuser is the result kind and
// out_tlast marks the final result of a command. A tick with nothing due gives
// no beat at all.
// The slot scan examines one slot per cycle: a cancel scans every slot, a tick
// scans every slot once to find the due timers, and each firing repeats a full
// scan to pick the earliest expiry (ties go to the oldest arming, then the lower
// slot).
// The output register holds a beat until out_tready; while it is held the
// engine waits before producing the next result, and the command queue keeps
// accepting until it is full.
// Synchronous reset clears all slots, sets time and arming count to zero and
// the next id to one; no clearing pass is needed.
`default_nettype none
module repeating_timer_queue #(
  parameter int NUM_SLOTS = rtq_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = rtq_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = rtq_pkg::TAG_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // interval_ticks[23:0], repeat_count[40:24], owner_tag[56:41], timer_id[88:57]
  input  wire logic [rtq_pkg::IN_DATA_W-1:0] in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]                    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // result_id[31:0], result_tag[47:32], cancel_count[52:48]
  output logic [rtq_pkg::OUT_DATA_W-1:0]     out_tdata,
  // kind[1:0]
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast
);
  import rtq_pkg::*;

  logic                  q_valid;
  logic                  q_ready;
  ctl_t                  q_ctl;
  logic [INTERVAL_W-1:0] q_interval;
  logic [REPEAT_W-1:0]   q_repeat;
  logic [TAG_BITS-1:0]   q_tag;
  logic [ID_W-1:0]       q_id;

  rtq_front #(
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_ctl      (q_ctl),
    .q_interval (q_interval),
    .q_repeat   (q_repeat),
    .q_tag      (q_tag),
    .q_id       (q_id)
  );

  rtq_back #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_ctl      (q_ctl),
    .q_interval (q_interval),
    .q_repeat   (q_repeat),
    .q_tag      (q_tag),
    .q_id       (q_id),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== sv/rtq_front.sv =====
// Front end: accepts command beats, classifies them and queues them for the back end.
`default_nettype none
module rtq_front #(
  parameter int TAG_BITS = rtq_pkg::TAG_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [rtq_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [1:0]                      in_tuser,
  output logic                                 q_valid,
  input  wire logic                            q_ready,
  output rtq_pkg::ctl_t                        q_ctl,
  output logic [rtq_pkg::INTERVAL_W-1:0]       q_interval,
  output logic [rtq_pkg::REPEAT_W-1:0]         q_repeat,
  output logic [TAG_BITS-1:0]                  q_tag,
  output logic [rtq_pkg::ID_W-1:0]             q_id
);
  import rtq_pkg::*;

  localparam int TAG_EXT = (TAG_BITS > OWNER_W) ? TAG_BITS : OWNER_W;

  logic [INTERVAL_W-1:0] f_interval;
  logic [REPEAT_W-1:0]   f_repeat;
  logic [OWNER_W-1:0]    f_owner;
  logic [ID_W-1:0]       f_id;
  logic [TAG_EXT-1:0]    owner_ext;
  logic [TAG_BITS-1:0]   tag_m;
  logic                  rep_neg;
  logic                  rep_many;
  ctl_t                  ctl_in;
  logic [INTERVAL_W-1:0] interval_n;
  logic [REPEAT_W-1:0]   repeat_n;

  ctl_t                  ctl_r      [2];
  logic [INTERVAL_W-1:0] interval_r [2];
  logic [REPEAT_W-1:0]   repeat_r   [2];
  logic [TAG_BITS-1:0]   tag_r      [2];
  logic [ID_W-1:0]       id_r       [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  push, pop;

  assign f_interval = in_tdata[23:0];
  assign f_repeat   = in_tdata[40:24];
  assign f_owner    = in_tdata[56:41];
  assign f_id       = in_tdata[88:57];
  assign owner_ext  = TAG_EXT'(f_owner);
  assign tag_m      = owner_ext[TAG_BITS-1:0];

  // Any negative count means forever; a repeating timer never gets a zero interval.
  always_comb begin
    rep_neg         = f_repeat[REPEAT_W-1];
    rep_many        = !rep_neg && (f_repeat[REPEAT_W-2:1] != '0);
    repeat_n        = rep_neg ? '1 : f_repeat;
    interval_n      = f_interval;
    if ((rep_neg || rep_many) && (f_interval == '0)) begin
      interval_n = INTERVAL_W'(1);
    end
    ctl_in.cmd      = cmd_t'(in_tuser);
    ctl_in.reject   = (f_repeat == '0);
    ctl_in.id_zero  = (f_id == '0);
    ctl_in.tag_zero = (tag_m == '0);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;

  assign q_ctl      = ctl_r[rd_ptr_r];
  assign q_interval = interval_r[rd_ptr_r];
  assign q_repeat   = repeat_r[rd_ptr_r];
  assign q_tag      = tag_r[rd_ptr_r];
  assign q_id       = id_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_r[wr_ptr_r]      <= ctl_in;
      interval_r[wr_ptr_r] <= interval_n;
      repeat_r[wr_ptr_r]   <= repeat_n;
      tag_r[wr_ptr_r]      <= tag_m;
      id_r[wr_ptr_r]       <= f_id;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rtq_back.sv =====
// Back end: slot table, time base, slot scan sequencer and the output register.
`default_nettype none
module rtq_back #(
  parameter int NUM_SLOTS = rtq_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = rtq_pkg::TIME_BITS_DEF,
  parameter int TAG_BITS  = rtq_pkg::TAG_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  output logic                                 q_ready,
  input  wire rtq_pkg::ctl_t                   q_ctl,
  input  wire logic [rtq_pkg::INTERVAL_W-1:0]  q_interval,
  input  wire logic [rtq_pkg::REPEAT_W-1:0]    q_repeat,
  input  wire logic [TAG_BITS-1:0]             q_tag,
  input  wire logic [rtq_pkg::ID_W-1:0]        q_id,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [rtq_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast
);
  import rtq_pkg::*;

  localparam int IDX_W   = $clog2(NUM_SLOTS);
  localparam int SUM_W   = (TIME_BITS > INTERVAL_W) ? TIME_BITS : INTERVAL_W;
  localparam int TAG_EXT = (TAG_BITS > OWNER_W) ? TAG_BITS : OWNER_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // Slot table.
  logic [NUM_SLOTS-1:0]  valid_r, valid_nxt;
  logic [ID_W-1:0]       id_r       [NUM_SLOTS];
  logic [TAG_BITS-1:0]   tag_r      [NUM_SLOTS];
  logic [INTERVAL_W-1:0] interval_r [NUM_SLOTS];
  logic [REPEAT_W-1:0]   repeat_r   [NUM_SLOTS];
  logic [TIME_BITS-1:0]  exp_r      [NUM_SLOTS];
  logic [AGE_W-1:0]      age_r      [NUM_SLOTS];

  // Time base and counters.
  logic [TIME_BITS-1:0]  now_r;
  logic [ID_W-1:0]       next_id_r;
  logic [AGE_W-1:0]      arm_cnt_r;
  logic [AGE_W-1:0]      tick_arm_r;

  // Current command.
  ctl_t                  ctl_r;
  logic [INTERVAL_W-1:0] c_interval_r;
  logic [REPEAT_W-1:0]   c_repeat_r;
  logic [TAG_BITS-1:0]   c_tag_r;
  logic [ID_W-1:0]       c_id_r;

  // Scan state.
  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      scan_r;
  logic [NUM_SLOTS-1:0]  pend_r;
  logic                  any_r;
  logic [COUNT_W-1:0]    count_r;
  logic                  found_r;
  logic [IDX_W-1:0]      best_r;
  logic [TIME_BITS-1:0]  best_late_r;
  logic [AGE_W-1:0]      best_old_r;

  // Output register.
  logic                  out_valid_r;
  kind_t                 out_kind_r;
  logic [ID_W-1:0]       out_id_r;
  logic [OWNER_W-1:0]    out_tag_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_last_r;

  // Datapath signals.
  logic [IDX_W-1:0]      rd_idx;
  logic [TIME_BITS-1:0]  rd_late;
  logic [AGE_W-1:0]      rd_old;
  logic                  rd_due;
  logic                  better;
  logic                  match;
  logic                  scan_end;
  logic [IDX_W-1:0]      free_idx;
  logic                  full;
  logic                  sched_err;
  logic [SUM_W-1:0]      arm_sum;
  logic [TIME_BITS-1:0]  arm_exp;
  logic [REPEAT_W-1:0]   rep_dec;
  logic                  fire_done;
  logic [NUM_SLOTS-1:0]  pend_left;
  logic [TAG_EXT-1:0]    fire_tag_ext;
  logic [ID_W-1:0]       id_inc;

  // Control from the output decode.
  logic                  emit_ok;
  logic                  do_pop;
  logic                  do_sched;
  logic                  do_cancel_out;
  logic                  do_fire;

  assign rd_idx   = (state_r == S_FIRE) ? best_r : scan_r;
  assign rd_late  = now_r - exp_r[rd_idx];
  assign rd_old   = tick_arm_r - age_r[rd_idx];
  assign rd_due   = valid_r[rd_idx] && !rd_late[TIME_BITS-1];
  assign better   = !found_r || (rd_late > best_late_r) ||
                    ((rd_late == best_late_r) && (rd_old > best_old_r));
  assign match    = valid_r[scan_r] &&
                    (((ctl_r.cmd == CMD_CANCEL_ID) && !ctl_r.id_zero &&
                      (id_r[scan_r] == c_id_r)) ||
                     ((ctl_r.cmd == CMD_CANCEL_TAG) && !ctl_r.tag_zero &&
                      (tag_r[scan_r] == c_tag_r)));
  assign scan_end = (scan_r == LAST_IDX);

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        free_idx = IDX_W'(s);
      end
    end
  end

  assign full      = &valid_r;
  assign sched_err = ctl_r.reject || full;

  // Arming time is shared by schedule (current command) and re-arm (fired slot).
  assign arm_sum  = SUM_W'(now_r) +
                    SUM_W'((state_r == S_FIRE) ? interval_r[best_r] : c_interval_r);
  assign arm_exp  = arm_sum[TIME_BITS-1:0];
  assign rep_dec  = repeat_r[best_r][REPEAT_W-1] ? repeat_r[best_r]
                                                 : repeat_r[best_r] - REPEAT_W'(1);
  assign fire_done    = (rep_dec == '0);
  assign pend_left    = pend_r & ~(NUM_SLOTS'(1) << best_r);
  assign fire_tag_ext = TAG_EXT'(tag_r[best_r]);
  assign id_inc       = (next_id_r + ID_W'(1) == '0) ? ID_W'(1) : next_id_r + ID_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_ctl.cmd)
            CMD_SCHED:                     state_nxt = S_SCHED;
            CMD_CANCEL_ID, CMD_CANCEL_TAG: state_nxt = S_CANCEL;
            CMD_TICK:                      state_nxt = S_PEND;
            default:                       state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCHED:      if (emit_ok) state_nxt = S_IDLE;
      S_CANCEL:     if (scan_end) state_nxt = S_CANCEL_OUT;
      S_CANCEL_OUT: if (emit_ok) state_nxt = S_IDLE;
      S_PEND: begin
        if (scan_end) state_nxt = (any_r || rd_due) ? S_SEL : S_IDLE;
      end
      S_SEL:        if (scan_end) state_nxt = S_FIRE;
      S_FIRE: begin
        if (emit_ok) state_nxt = (pend_left == '0) ? S_IDLE : S_SEL;
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    emit_ok       = !out_valid_r || out_tready;
    do_pop        = (state_r == S_IDLE) && q_valid;
    do_sched      = (state_r == S_SCHED) && emit_ok;
    do_cancel_out = (state_r == S_CANCEL_OUT) && emit_ok;
    do_fire       = (state_r == S_FIRE) && emit_ok;
    q_ready       = (state_r == S_IDLE);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (do_sched && !sched_err) begin
      valid_nxt[free_idx] = 1'b1;
    end
    if ((state_r == S_CANCEL) && match) begin
      valid_nxt[scan_r] = 1'b0;
    end
    if (do_fire && fire_done) begin
      valid_nxt[best_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      now_r       <= '0;
      next_id_r   <= ID_W'(1);
      arm_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (do_pop && (q_ctl.cmd == CMD_TICK)) begin
        now_r <= now_r + TIME_BITS'(1);
      end
      if (do_sched && !sched_err) begin
        next_id_r <= id_inc;
      end
      if ((do_sched && !sched_err) || (do_fire && !fire_done)) begin
        arm_cnt_r <= arm_cnt_r + AGE_W'(1);
      end
      if (do_sched || do_cancel_out || do_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      ctl_r        <= q_ctl;
      c_interval_r <= q_interval;
      c_repeat_r   <= q_repeat;
      c_tag_r      <= q_tag;
      c_id_r       <= q_id;
      scan_r       <= '0;
      count_r      <= '0;
      any_r        <= 1'b0;
      tick_arm_r   <= arm_cnt_r;
    end
    if (state_r == S_CANCEL) begin
      scan_r <= scan_r + IDX_W'(1);
      if (match) count_r <= count_r + COUNT_W'(1);
    end
    if (state_r == S_PEND) begin
      pend_r[scan_r] <= rd_due;
      any_r          <= any_r || rd_due;
      scan_r         <= scan_r + IDX_W'(1);
      found_r        <= 1'b0;
    end
    if (state_r == S_SEL) begin
      scan_r <= scan_r + IDX_W'(1);
      if (pend_r[scan_r] && better) begin
        found_r     <= 1'b1;
        best_r      <= scan_r;
        best_late_r <= rd_late;
        best_old_r  <= rd_old;
      end
    end
    if (do_sched && !sched_err) begin
      id_r[free_idx]       <= next_id_r;
      tag_r[free_idx]      <= c_tag_r;
      interval_r[free_idx] <= c_interval_r;
      repeat_r[free_idx]   <= c_repeat_r;
      exp_r[free_idx]      <= arm_exp;
      age_r[free_idx]      <= arm_cnt_r;
    end
    if (do_fire) begin
      pend_r             <= pend_left;
      found_r            <= 1'b0;
      scan_r             <= '0;
      repeat_r[best_r]   <= rep_dec;
      if (!fire_done) begin
        exp_r[best_r] <= arm_exp;
        age_r[best_r] <= arm_cnt_r;
      end
    end
    if (do_sched) begin
      out_kind_r  <= sched_err ? KIND_ERROR : KIND_SCHED;
      out_id_r    <= sched_err ? '0 : next_id_r;
      out_tag_r   <= '0;
      out_count_r <= '0;
      out_last_r  <= 1'b1;
    end
    if (do_cancel_out) begin
      out_kind_r  <= KIND_CANCEL;
      out_id_r    <= '0;
      out_tag_r   <= '0;
      out_count_r <= count_r;
      out_last_r  <= 1'b1;
    end
    if (do_fire) begin
      out_kind_r  <= KIND_FIRED;
      out_id_r    <= id_r[best_r];
      out_tag_r   <= fire_tag_ext[OWNER_W-1:0];
      out_count_r <= '0;
      out_last_r  <= (pend_left == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_count_r, out_tag_r, out_id_r};

endmodule
`default_nettype wire

// ===== sv/rtq_checker.sv =====
// Port-level checks of the repeating timer queue and their binding.
`default_nettype none
module rtq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [rtq_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [1:0]                    out_tuser,
  input wire logic                          out_tlast
);
  import rtq_pkg::*;

  // A held beat stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat offered right after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ERROR) |-> (out_tdata == '0) && out_tlast)
    else $error("error beat carries data");

  a_sched_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_SCHED) |-> (out_tdata[31:0] != '0) && out_tlast)
    else $error("schedule beat without a valid id");

  a_cancel_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_CANCEL) |-> out_tlast && (out_tdata[47:0] == '0))
    else $error("cancel beat malformed");

endmodule

bind repeating_timer_queue rtq_checker u_rtq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
